// File: rtl/core/abpd_pkg.sv
// shared constants, types and codes of the auto brightness pwm duty block
package abpd_pkg;

  // window and sensor scale
  localparam int unsigned WINDOW     = 100;
  localparam int unsigned FULL_SCALE = 1024;

  // field widths
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned ENTRY_W  = $clog2(FULL_SCALE + 1);
  localparam int unsigned AVG_W    = 11;
  localparam int unsigned SUM_W    = $clog2(WINDOW * FULL_SCALE + 1);
  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned MODE_W   = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // percent scale
  localparam int unsigned PCT_MAX = 100;

  // reciprocal of the window: floor(2^AVG_SHIFT / WINDOW), quotient low by at most one
  localparam int unsigned AVG_SHIFT = SUM_W + 2;
  localparam int unsigned AVG_MUL   = (2 ** AVG_SHIFT) / WINDOW;
  localparam int unsigned AVG_MUL_W = $clog2(AVG_MUL + 1);
  localparam int unsigned AVG_PROD_W = SUM_W + AVG_MUL_W;

  // reciprocal of one hundred for the match value
  localparam int unsigned PROD_W      = PERIOD_W + PCT_W;
  localparam int unsigned MATCH_SHIFT = PROD_W + 2;
  localparam longint unsigned MATCH_MUL = (64'd1 << MATCH_SHIFT) / PCT_MAX;
  localparam int unsigned MATCH_MUL_W = $clog2(MATCH_MUL + 1);
  localparam int unsigned MATCH_PROD_W = PROD_W + MATCH_MUL_W;
  localparam int unsigned MATCH_Q_W   = MATCH_PROD_W - MATCH_SHIFT;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_COUNT    = 3'd0,
    REG_BRIGHTNESS_MODE = 3'd1,
    REG_MIN_PERCENT     = 3'd2,
    REG_BRIGHT_DUTY     = 3'd3,
    REG_MEDIUM_DUTY     = 3'd4,
    REG_DIM_DUTY        = 3'd5
  } cfg_reg_e;

  // brightness modes
  typedef enum logic [MODE_W-1:0] {
    MODE_AUTO   = 2'd0,
    MODE_BRIGHT = 2'd1,
    MODE_MEDIUM = 2'd2,
    MODE_DIM    = 2'd3
  } brightness_mode_e;

endpackage

// File: rtl/core/auto_brightness_pwm_duty.sv
// top level: light sample window, brightness percent and pwm match value
//
// Takes one light sample per clock while in_stall_o is low and returns one
// result per sample, in order. The window is a row of 100 register cells
// that shift on each sample in auto mode, with a running sum, so a new sample
// can follow every cycle. The average and the match value divide by constants
// through a registered reciprocal multiply and a one-step correction. The
// pipeline advances whenever the output register is empty or being taken, so
// in_stall_o follows out_stall_i only while a result is waiting. The user
// writes registers only while the block is idle; the block does not enforce
// it. cfg_ready_o is always high and writes to unused indexes are dropped.
module auto_brightness_pwm_duty (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [abpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [abpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // sample input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [abpd_pkg::SAMPLE_W-1:0]   light_sample_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [abpd_pkg::PERIOD_W-1:0]   match_value_o,
  output logic [abpd_pkg::PCT_W-1:0]      duty_percent_o,
  output logic [abpd_pkg::AVG_W-1:0]      light_average_o
);
  import abpd_pkg::*;

  function automatic logic [PCT_W-1:0] limit_duty(input logic [PCT_W-1:0] d);
    logic [PCT_W-1:0] r;
    r = d;
    if (r < PCT_W'(1)) r = PCT_W'(1);
    if (r > PCT_W'(PCT_MAX)) r = PCT_W'(PCT_MAX);
    return r;
  endfunction

  // configuration registers
  logic [PERIOD_W-1:0] period_q;
  brightness_mode_e    mode_q;
  logic [PCT_W-1:0]    min_pct_q;
  logic [PCT_W-1:0]    bright_q;
  logic [PCT_W-1:0]    medium_q;
  logic [PCT_W-1:0]    dim_q;

  // pipeline control
  logic advance;
  logic accept;
  logic auto_mode;

  // window
  logic [SUM_W-1:0] ring_sum;
  logic [SUM_W-1:0] ring_sum_next;

  // stage registers
  logic                    v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, vo_q;
  logic [SUM_W-1:0]        sum1_q, sum2_q;
  logic [AVG_PROD_W-1:0]   aprod2_q;
  logic [AVG_W-1:0]        avg3_q, avg4_q, avg5_q, avg6_q, avgo_q;
  logic [PCT_W-1:0]        duty4_q, duty5_q, duty6_q, dutyo_q;
  logic [PROD_W-1:0]       mprod5_q, mprod6_q;
  logic [MATCH_PROD_W-1:0] rprod6_q;
  logic [PERIOD_W-1:0]     matcho_q;

  // combinational helpers
  logic [AVG_W-1:0]     avg_est;
  logic [SUM_W-1:0]     avg_rem;
  logic [AVG_W-1:0]     avg_fix;
  logic [ENTRY_W-1:0]   avg_clamp;
  logic [ENTRY_W-1:0]   avg_diff;
  logic [SUM_W-1:0]     drop_scaled;
  logic [PCT_W-1:0]     pct_drop;
  logic [PCT_W-1:0]     pct_raw;
  logic [PCT_W-1:0]     duty_d;
  logic [PCT_W-1:0]     duty_inv;
  logic [MATCH_Q_W-1:0] match_est;
  logic [PROD_W-1:0]    match_rem;
  logic [PERIOD_W-1:0]  match_fix;

  assign cfg_ready_o = 1'b1;
  assign advance     = !vo_q || !out_stall_i;
  assign in_stall_o  = !advance;
  assign accept      = in_valid_i && advance;
  assign auto_mode   = (mode_q == MODE_AUTO);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= PERIOD_W'(720000);
      mode_q    <= MODE_MEDIUM;
      min_pct_q <= PCT_W'(10);
      bright_q  <= PCT_W'(100);
      medium_q  <= PCT_W'(50);
      dim_q     <= PCT_W'(10);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PERIOD_COUNT:    period_q  <= cfg_data_i[PERIOD_W-1:0];
        REG_BRIGHTNESS_MODE: mode_q    <= brightness_mode_e'(cfg_data_i[MODE_W-1:0]);
        REG_MIN_PERCENT:     min_pct_q <= cfg_data_i[PCT_W-1:0];
        REG_BRIGHT_DUTY:     bright_q  <= cfg_data_i[PCT_W-1:0];
        REG_MEDIUM_DUTY:     medium_q  <= cfg_data_i[PCT_W-1:0];
        REG_DIM_DUTY:        dim_q     <= cfg_data_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // window shifts only for samples taken in auto mode
  abpd_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (accept && auto_mode),
    .sample_i  (light_sample_i),
    .sum_o     (ring_sum),
    .sum_next_o(ring_sum_next)
  );

  // average correction: estimate is low by at most one
  assign avg_est = aprod2_q[AVG_SHIFT +: AVG_W];
  assign avg_rem = sum2_q - SUM_W'(avg_est) * SUM_W'(WINDOW);
  assign avg_fix = (avg_rem >= SUM_W'(WINDOW)) ? avg_est + AVG_W'(1) : avg_est;

  // brightness percent from the average
  assign avg_clamp   = (avg3_q > AVG_W'(FULL_SCALE)) ? ENTRY_W'(FULL_SCALE)
                                                      : ENTRY_W'(avg3_q);
  assign avg_diff    = ENTRY_W'(FULL_SCALE) - avg_clamp;
  assign drop_scaled = (SUM_W'(avg_diff) * SUM_W'(PCT_MAX)) / SUM_W'(FULL_SCALE);
  assign pct_drop    = drop_scaled[PCT_W-1:0];
  assign pct_raw     = PCT_W'(PCT_MAX) - pct_drop;

  // duty selection per mode
  always_comb begin
    unique case (mode_q)
      MODE_AUTO:   duty_d = limit_duty((pct_raw < min_pct_q) ? min_pct_q : pct_raw);
      MODE_BRIGHT: duty_d = limit_duty(bright_q);
      MODE_MEDIUM: duty_d = limit_duty(medium_q);
      MODE_DIM:    duty_d = limit_duty(dim_q);
      default:     duty_d = limit_duty(medium_q);
    endcase
  end

  assign duty_inv = PCT_W'(PCT_MAX) - duty4_q;

  // match value correction: estimate is low by at most one
  assign match_est = rprod6_q[MATCH_SHIFT +: MATCH_Q_W];
  assign match_rem = mprod6_q - PROD_W'(match_est) * PROD_W'(PCT_MAX);
  assign match_fix = (match_rem >= PROD_W'(PCT_MAX))
                     ? PERIOD_W'(match_est) + PERIOD_W'(1) : PERIOD_W'(match_est);

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (advance) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      vo_q <= v6_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      sum1_q   <= auto_mode ? ring_sum_next : ring_sum;
      sum2_q   <= sum1_q;
      aprod2_q <= AVG_PROD_W'(sum1_q) * AVG_PROD_W'(AVG_MUL);
      avg3_q   <= avg_fix;
      avg4_q   <= avg3_q;
      duty4_q  <= duty_d;
      avg5_q   <= avg4_q;
      duty5_q  <= duty4_q;
      mprod5_q <= PROD_W'(period_q) * PROD_W'(duty_inv);
      avg6_q   <= avg5_q;
      duty6_q  <= duty5_q;
      mprod6_q <= mprod5_q;
      rprod6_q <= MATCH_PROD_W'(mprod5_q) * MATCH_PROD_W'(MATCH_MUL);
      avgo_q   <= avg6_q;
      dutyo_q  <= duty6_q;
      matcho_q <= match_fix;
    end
  end

  assign out_valid_o     = vo_q;
  assign match_value_o   = matcho_q;
  assign duty_percent_o  = dutyo_q;
  assign light_average_o = avgo_q;

endmodule

// File: rtl/core/abpd_cell.sv
// one entry of the sample window, shifting to its neighbor
module abpd_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  logic [abpd_pkg::ENTRY_W-1:0] data_i,
  output logic [abpd_pkg::ENTRY_W-1:0] data_o
);
  import abpd_pkg::*;

  logic [ENTRY_W-1:0] entry_q;

  // entry starts at full scale, takes the neighbor value on a shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= ENTRY_W'(FULL_SCALE);
    end else if (shift_i) begin
      entry_q <= data_i;
    end
  end

  assign data_o = entry_q;

endmodule

// File: rtl/core/abpd_ring.sv
// window of samples as a row of shifting cells, with its running sum
module abpd_ring (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic [abpd_pkg::SAMPLE_W-1:0] sample_i,
  output logic [abpd_pkg::SUM_W-1:0]    sum_o,
  output logic [abpd_pkg::SUM_W-1:0]    sum_next_o
);
  import abpd_pkg::*;

  logic [ENTRY_W-1:0] link [WINDOW+1];
  logic [SUM_W-1:0]   sum_q;
  logic [SUM_W-1:0]   sum_d;

  assign link[0] = ENTRY_W'(sample_i);

  // newest sample enters cell zero, the oldest leaves the last cell
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    abpd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift_i),
      .data_i (link[k]),
      .data_o (link[k+1])
    );
  end

  // running sum drops the oldest entry and adds the new sample
  assign sum_d = sum_q - SUM_W'(link[WINDOW]) + SUM_W'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= SUM_W'(WINDOW * FULL_SCALE);
    end else if (shift_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o      = sum_q;
  assign sum_next_o = sum_d;

endmodule

// File: tb/sv/auto_brightness_pwm_duty_tb.sv
// testbench of the auto brightness pwm duty block: driver, monitor and duty predictor
module auto_brightness_pwm_duty_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import abpd_pkg::*;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASES      = 15;
  localparam int unsigned PHASE_ITEMS = 110;
  localparam int unsigned PRINT_CAP   = 30;

  // pacing of the two channels
  typedef enum int {PACE_RX_HEAVY, PACE_TX_HEAVY, PACE_NONE} pace_e;

  // light pattern of a random phase
  typedef enum int {SCENE_UNIFORM, SCENE_DARK, SCENE_BLACK, SCENE_BRIGHT, SCENE_LEVEL} scene_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] match_value;
    logic [PCT_W-1:0]    duty_percent;
    logic [AVG_W-1:0]    light_average;
  } pwm_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   light_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PERIOD_W-1:0]   match_value_o;
  logic [PCT_W-1:0]      duty_percent_o;
  logic [AVG_W-1:0]      light_average_o;

  // predictor copy of the registers
  logic [PERIOD_W-1:0] cur_period;
  brightness_mode_e    cur_mode;
  logic [PCT_W-1:0]    cur_min_pct;
  logic [PCT_W-1:0]    cur_bright;
  logic [PCT_W-1:0]    cur_medium;
  logic [PCT_W-1:0]    cur_dim;

  // predictor copy of the sample window
  int unsigned light_ring [WINDOW];
  int unsigned ring_pos;
  int unsigned window_sum;

  logic [SAMPLE_W-1:0] light_queue [$];
  pwm_result_t         pwm_expect_q [$];

  pace_e       pace = PACE_RX_HEAVY;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  bit          sample_taken = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned samples_sent = 0;
  int unsigned auto_samples = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;

  auto_brightness_pwm_duty i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .light_sample_i  (light_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .match_value_o   (match_value_o),
    .duty_percent_o  (duty_percent_o),
    .light_average_o (light_average_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // register state after reset
  task automatic reset_predictor();
    for (int k = 0; k < WINDOW; k++) light_ring[k] = FULL_SCALE;
    ring_pos    = 0;
    window_sum  = WINDOW * FULL_SCALE;
    cur_period  = 24'd720000;
    cur_mode    = MODE_MEDIUM;
    cur_min_pct = 7'd10;
    cur_bright  = 7'd100;
    cur_medium  = 7'd50;
    cur_dim     = 7'd10;
  endtask

  // one sample through the window, duty and match value
  task automatic advance_light_window(input logic [SAMPLE_W-1:0] sample,
                                      output pwm_result_t res);
    int unsigned     avg;
    int unsigned     clamped;
    int unsigned     pct;
    longint unsigned prod;
    if (cur_mode == MODE_AUTO) begin
      window_sum = window_sum - light_ring[ring_pos] + sample;
      light_ring[ring_pos] = sample;
      ring_pos = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
      avg = window_sum / WINDOW;
      clamped = (avg > FULL_SCALE) ? FULL_SCALE : avg;
      pct = PCT_MAX - (PCT_MAX * (FULL_SCALE - clamped)) / FULL_SCALE;
      if (pct < cur_min_pct) pct = cur_min_pct;
      auto_samples++;
    end else begin
      avg = window_sum / WINDOW;
      case (cur_mode)
        MODE_BRIGHT: pct = cur_bright;
        MODE_MEDIUM: pct = cur_medium;
        default:     pct = cur_dim;
      endcase
    end
    // duty is kept within one to a hundred percent
    if (pct < 1) pct = 1;
    if (pct > PCT_MAX) pct = PCT_MAX;
    prod = 64'(cur_period);
    prod = prod * (PCT_MAX - pct) / PCT_MAX;
    res.match_value   = prod[PERIOD_W-1:0];
    res.duty_percent  = pct[PCT_W-1:0];
    res.light_average = avg[AVG_W-1:0];
  endtask

  // sender: next sample at the falling edge, held until its transfer
  always @(negedge clk_i) begin : sender
    logic                nv;
    logic [SAMPLE_W-1:0] ns;
    int unsigned         gap_pct;
    nv = in_valid_i;
    ns = light_sample_i;
    gap_pct = (pace == PACE_RX_HEAVY) ? 20 : (pace == PACE_TX_HEAVY) ? 45 : 0;
    if (rst_ni && (!in_valid_i || sample_taken)) begin
      nv = 1'b0;
      if (light_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nv = 1'b1;
        ns = light_queue.pop_front();
      end
    end
    in_valid_i     <= nv;
    light_sample_i <= ns;
  end

  // receiver: random stall, plus a long hold-off on request
  always @(negedge clk_i) begin : receiver
    logic        nstall;
    int unsigned stall_pct;
    stall_pct = (pace == PACE_RX_HEAVY) ? 45 : (pace == PACE_TX_HEAVY) ? 20 : 0;
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      nstall = 1'b1;
    end else begin
      nstall = ($urandom_range(99) < stall_pct);
    end
    out_stall_i <= nstall;
  end

  // monitor: check results, predict accepted samples
  always @(posedge clk_i) begin : monitor
    pwm_result_t want;
    pwm_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{match_value_o, duty_percent_o, light_average_o};
      if (pwm_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
          $display("%0t: result with none expected: match %0d duty %0d avg %0d",
                   $time, got.match_value, got.duty_percent, got.light_average);
      end else begin
        want = pwm_expect_q.pop_front();
        results_checked++;
        if (got.match_value !== want.match_value) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_CAP)
            $display("%0t: match_value expected %0d actual %0d",
                     $time, want.match_value, got.match_value);
        end
        if (got.duty_percent !== want.duty_percent) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_CAP)
            $display("%0t: duty_percent expected %0d actual %0d",
                     $time, want.duty_percent, got.duty_percent);
        end
        if (got.light_average !== want.light_average) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_CAP)
            $display("%0t: light_average expected %0d actual %0d",
                     $time, want.light_average, got.light_average);
        end
      end
    end
    sample_taken = rst_ni && in_valid_i && !in_stall_o;
    if (sample_taken) begin
      advance_light_window(light_sample_i, want);
      pwm_expect_q.push_back(want);
      samples_sent++;
    end
  end

  // one register write transfer, mirrored into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
    case (idx)
      REG_PERIOD_COUNT:    cur_period  = data[PERIOD_W-1:0];
      REG_BRIGHTNESS_MODE: cur_mode    = brightness_mode_e'(data[MODE_W-1:0]);
      REG_MIN_PERCENT:     cur_min_pct = data[PCT_W-1:0];
      REG_BRIGHT_DUTY:     cur_bright  = data[PCT_W-1:0];
      REG_MEDIUM_DUTY:     cur_medium  = data[PCT_W-1:0];
      REG_DIM_DUTY:        cur_dim     = data[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every sample is sent and every result is back
  task automatic drain();
    do @(posedge clk_i);
    while (light_queue.size() != 0 || in_valid_i || pwm_expect_q.size() != 0);
  endtask

  // percent register value, extremes and out of range included
  function automatic logic [CFG_DATA_W-1:0] pick_percent();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(7))
      0:       v = '0;
      1:       v = CFG_DATA_W'(1);
      2:       v = CFG_DATA_W'(PCT_MAX);
      3:       v = CFG_DATA_W'(127);
      default: v = CFG_DATA_W'($urandom_range(1, PCT_MAX));
    endcase
    // junk above the register width now and then
    if ($urandom_range(3) == 0) v = v | CFG_DATA_W'($urandom() & 24'hFFFF80);
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_period();
    case ($urandom_range(5))
      0:       return '0;
      1:       return CFG_DATA_W'(1);
      2:       return 24'hFFFFFF;
      3:       return 24'd720000;
      default: return CFG_DATA_W'($urandom());
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_light(scene_e scene, int unsigned level);
    int unsigned v;
    case (scene)
      SCENE_DARK:   v = ($urandom_range(9) == 0) ? $urandom_range(15) : 0;
      SCENE_BLACK:  v = 0;
      SCENE_BRIGHT: v = ($urandom_range(9) == 0) ? $urandom_range(1000, 1023) : 1023;
      SCENE_LEVEL: begin
        v = level + $urandom_range(64);
        v = (v < 32) ? 0 : (v - 32 > 1023) ? 1023 : v - 32;
      end
      default:      v = $urandom_range(1023);
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // stimulus and end of run
  initial begin : stimulus
    logic [MODE_W-1:0] mode_pick;
    scene_e            scene;
    int unsigned       level;
    reset_predictor();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: manual medium
    light_queue.push_back(10'h000);
    light_queue.push_back(10'h3FF);
    drain();

    // writes to unused indexes leave everything as it was
    write_reg(REG_SPARE_LO, 24'hFFFFFF);
    write_reg(REG_SPARE_HI, 24'hFFFFFF);
    end_writes();
    light_queue.push_back(10'h155);
    drain();

    // auto mode at full period and lowest floor
    write_reg(REG_PERIOD_COUNT, 24'hFFFFFF);
    write_reg(REG_BRIGHTNESS_MODE, 24'hFFFFFC);
    write_reg(REG_MIN_PERCENT, 24'd1);
    end_writes();
    light_queue.push_back(10'h3FF);
    light_queue.push_back(10'h000);
    light_queue.push_back(10'h2AA);
    light_queue.push_back(10'h155);
    light_queue.push_back(10'h200);
    drain();

    // floor above one hundred saturates, floor of zero
    write_reg(REG_MIN_PERCENT, 24'd127);
    end_writes();
    light_queue.push_back(10'h000);
    drain();
    write_reg(REG_MIN_PERCENT, 24'd0);
    end_writes();
    light_queue.push_back(10'h001);
    drain();

    // manual duty of zero and above one hundred
    write_reg(REG_BRIGHTNESS_MODE, CFG_DATA_W'(MODE_BRIGHT));
    write_reg(REG_BRIGHT_DUTY, 24'd0);
    end_writes();
    light_queue.push_back(10'h3FE);
    drain();
    write_reg(REG_BRIGHT_DUTY, 24'd127);
    end_writes();
    light_queue.push_back(10'h0FF);
    drain();
    write_reg(REG_BRIGHTNESS_MODE, CFG_DATA_W'(MODE_MEDIUM));
    write_reg(REG_MEDIUM_DUTY, 24'd100);
    end_writes();
    light_queue.push_back(10'h300);
    drain();
    write_reg(REG_BRIGHTNESS_MODE, CFG_DATA_W'(MODE_DIM));
    write_reg(REG_DIM_DUTY, 24'd0);
    end_writes();
    light_queue.push_back(10'h0AA);
    drain();

    // zero period, then the smallest nonzero one
    write_reg(REG_PERIOD_COUNT, 24'd0);
    write_reg(REG_DIM_DUTY, 24'd50);
    end_writes();
    light_queue.push_back(10'h111);
    drain();
    write_reg(REG_PERIOD_COUNT, 24'd1);
    end_writes();
    light_queue.push_back(10'h222);
    drain();

    // random phases, each with its own settings and light pattern
    for (int p = 0; p < PHASES; p++) begin
      pace = pace_e'(p / 5);
      write_reg(REG_PERIOD_COUNT, pick_period());
      mode_pick = ($urandom_range(9) < 7) ? MODE_AUTO : MODE_W'($urandom_range(3));
      write_reg(REG_BRIGHTNESS_MODE,
                CFG_DATA_W'(($urandom() & 24'hFFFFFC) | mode_pick));
      write_reg(REG_MIN_PERCENT, pick_percent());
      write_reg(REG_BRIGHT_DUTY, pick_percent());
      write_reg(REG_MEDIUM_DUTY, pick_percent());
      write_reg(REG_DIM_DUTY, pick_percent());
      if ($urandom_range(3) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom()));
      end_writes();
      scene = scene_e'($urandom_range(4));
      level = $urandom_range(1023);
      for (int n = 0; n < PHASE_ITEMS; n++) light_queue.push_back(pick_light(scene, level));
      // long output hold-off while samples keep coming
      if (p == 2 || p == 7) hold_asks++;
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (pwm_expect_q.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d results never arrived", $time, pwm_expect_q.size());
    end
    $display("run covered %0d sample transfers (%0d in auto mode) over %0d register writes",
             samples_sent, auto_samples, reg_writes);
    $display("%0d results checked, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #4_000_000;
    $display("%0t: run limit reached", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
